### src/lft_pkg.sv
package lft_pkg;

	localparam int DEF_CAPACITY = 256;

	localparam int ADDR_W  = 32;
	localparam int PORT_W  = 16;
	localparam int PROTO_W = 8;
	localparam int VER_W   = 4;
	localparam int FLAGS_W = 8;
	localparam int STAMP_W = 32;
	localparam int IN_W    = 152;

	localparam int OUTC_W  = 2;
	localparam int OSLOT_W = 8;
	localparam int CFG_W   = 9;
	localparam int OUT_W   = 32;

	localparam logic [CFG_W-1:0]   MAX_FLOWS_RST = 9'd256;
	localparam logic [PROTO_W-1:0] PROTO_TCP     = 8'd6;
	localparam int FLAG_SYN = 1;
	localparam int FLAG_ACK = 4;

	localparam logic [OUTC_W-1:0] OUTC_HIT  = 2'd0;
	localparam logic [OUTC_W-1:0] OUTC_NEW  = 2'd1;
	localparam logic [OUTC_W-1:0] OUTC_DROP = 2'd2;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_HIT,
		CMD_EVICT,
		CMD_INSERT
	} cmd_op_t;

endpackage

### src/lft_cell.sv
module lft_cell #(
	parameter int IDX_W   = 8,
	parameter int CELL_ID = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [lft_pkg::ADDR_W-1:0]  key_src,
	input  logic [lft_pkg::ADDR_W-1:0]  key_dst,
	input  logic [2*lft_pkg::PORT_W-1:0] key_ports,
	input  logic [2+3*IDX_W-1:0]        cmd,
	input  logic [4+5*IDX_W-1:0]        carry_in,
	output logic [4+5*IDX_W-1:0]        carry_out
);
	import lft_pkg::*;

	typedef struct packed {
		cmd_op_t          op;
		logic [IDX_W-1:0] slot;
		logic [IDX_W-1:0] rank;
		logic [IDX_W-1:0] ref_rank;
	} cmd_t;

	typedef struct packed {
		logic             vld;
		logic             pair;
		logic             hit;
		logic [IDX_W-1:0] hit_slot;
		logic [IDX_W-1:0] hit_rank;
		logic [IDX_W-1:0] r0_slot;
		logic [IDX_W-1:0] r1_slot;
		logic             free_fnd;
		logic [IDX_W-1:0] free_slot;
	} carry_t;

	localparam logic [IDX_W-1:0] MY_ID = IDX_W'(CELL_ID);

	cmd_t   c;
	carry_t ci, co_d, co_q;

	logic                  valid_q;
	logic [IDX_W-1:0]      rank_q;
	logic [ADDR_W-1:0]     src_q, dst_q;
	logic [2*PORT_W-1:0]   ports_q;
	logic                  pair_m, full_m, is_slot;

	assign c         = cmd_t'(cmd);
	assign ci        = carry_t'(carry_in);
	assign carry_out = co_q;
	assign is_slot   = (c.slot == MY_ID);
	assign pair_m    = valid_q && (src_q == key_src) && (dst_q == key_dst);
	assign full_m    = pair_m && (ports_q == key_ports);

	always_comb begin
		co_d      = ci;
		co_d.pair = ci.pair | pair_m;
		if (!ci.hit && full_m) begin
			co_d.hit      = 1'b1;
			co_d.hit_slot = MY_ID;
			co_d.hit_rank = rank_q;
		end
		if (valid_q && rank_q == '0) begin
			co_d.r0_slot = MY_ID;
		end
		if (valid_q && rank_q == IDX_W'(1)) begin
			co_d.r1_slot = MY_ID;
		end
		if (!ci.free_fnd && !valid_q) begin
			co_d.free_fnd  = 1'b1;
			co_d.free_slot = MY_ID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			co_q <= '0;
		end else begin
			co_q <= co_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else begin
			case (c.op)
				CMD_HIT: begin
					if (is_slot) begin
						rank_q <= c.rank;
					end else if (valid_q && rank_q > c.ref_rank) begin
						rank_q <= rank_q - IDX_W'(1);
					end
				end
				CMD_EVICT: begin
					if (valid_q) begin
						if (rank_q == '0) begin
							valid_q <= 1'b0;
						end else begin
							rank_q <= rank_q - IDX_W'(1);
						end
					end
				end
				CMD_INSERT: begin
					if (is_slot) begin
						valid_q <= 1'b1;
						rank_q  <= c.rank;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (c.op == CMD_INSERT && is_slot) begin
			src_q   <= key_src;
			dst_q   <= key_dst;
			ports_q <= key_ports;
		end
	end

endmodule

### src/lru_flow_table_top.sv
// LRU flow cache for IPv4 packet headers.
// Headers enter on the s_ stream channel, one per transaction, and each one
// produces exactly one result transaction on the m_ stream channel.
// The max_flows register is written through cfg_we and cfg_data; the user
// must do so only while the block is idle, which the block does not enforce.
// It sets the fill level at which the oldest flow is evicted.
// Flows live in a row of CAPACITY cells. A lookup sends a search record
// down the row, one cell per cycle. A header then takes a hit update on a
// hit, one eviction step per evicted flow, and, when a new flow is inserted,
// a second pass along the row to find the free slot.
// A new header is taken while the previous result still waits in the
// output register; a stalled receiver holds the block once the next result
// is ready.
// Reset empties the table and sets max_flows to 256.
module lru_flow_table_top #(
	parameter int CAPACITY = lft_pkg::DEF_CAPACITY
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// src_addr, dst_addr, src_port, dst_port, proto_num, ip_version,
	// tcp_flags, stamp, zero fill
	input  logic [lft_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// outcome, evicted, evicted_slot, flow_slot, flow_count, zero fill
	output logic [lft_pkg::OUT_W-1:0] m_tdata,
	input  logic                      cfg_we,
	input  logic [lft_pkg::CFG_W-1:0] cfg_data
);
	import lft_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int OCC_W = $clog2(CAPACITY + 1);
	localparam int LW    = (OCC_W > CFG_W) ? OCC_W : CFG_W;
	localparam int SW    = (IDX_W > OSLOT_W) ? IDX_W : OSLOT_W;
	localparam int CW    = (OCC_W > CFG_W) ? OCC_W : CFG_W;
	localparam int CMD_W = 2 + 3 * IDX_W;
	localparam int CAR_W = 4 + 5 * IDX_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOOK  = 3'd1;
	localparam logic [2:0] ST_HIT   = 3'd2;
	localparam logic [2:0] ST_EVICT = 3'd3;
	localparam logic [2:0] ST_FREE  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	typedef struct packed {
		cmd_op_t          op;
		logic [IDX_W-1:0] slot;
		logic [IDX_W-1:0] rank;
		logic [IDX_W-1:0] ref_rank;
	} cmd_t;

	typedef struct packed {
		logic             vld;
		logic             pair;
		logic             hit;
		logic [IDX_W-1:0] hit_slot;
		logic [IDX_W-1:0] hit_rank;
		logic [IDX_W-1:0] r0_slot;
		logic [IDX_W-1:0] r1_slot;
		logic             free_fnd;
		logic [IDX_W-1:0] free_slot;
	} carry_t;

	logic [2:0]          state_q;
	logic                start_q;
	logic [CFG_W-1:0]    max_flows_q;
	logic [OCC_W-1:0]    occ_q;
	logic [ADDR_W-1:0]   src_q, dst_q;
	logic [2*PORT_W-1:0] ports_q;
	logic [PROTO_W-1:0]  proto_q;
	logic [FLAGS_W-1:0]  flags_q;
	logic                ins_q, evicted_q;
	logic [IDX_W-1:0]    hit_slot_q, hit_rank_q, oldest_q, ev_slot_q, flow_slot_q;
	logic [OUTC_W-1:0]   outc_q;
	logic [OUT_W-1:0]    m_data_q;
	logic                m_valid_q;

	cmd_t                cmd;
	carry_t              start_carry, res;
	logic [CAR_W-1:0]    chain [CAPACITY+1];
	logic [LW-1:0]       limit, occ_ext;
	logic                need_evict, ins_d;
	logic [IDX_W-1:0]    oldest_d;
	logic [SW-1:0]       ev_ext, flow_ext;
	logic [CW-1:0]       cnt_ext;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	always_comb begin
		start_carry     = '0;
		start_carry.vld = start_q;
	end
	assign chain[0] = start_carry;
	assign res      = carry_t'(chain[CAPACITY]);

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		lft_cell #(
			.IDX_W  (IDX_W),
			.CELL_ID(g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.key_src  (src_q),
			.key_dst  (dst_q),
			.key_ports(ports_q),
			.cmd      (CMD_W'(cmd)),
			.carry_in (chain[g]),
			.carry_out(chain[g+1])
		);
	end

	always_comb begin
		if (max_flows_q == '0) begin
			limit = LW'(1);
		end else if (LW'(max_flows_q) > LW'(CAPACITY)) begin
			limit = LW'(CAPACITY);
		end else begin
			limit = LW'(max_flows_q);
		end
	end
	assign occ_ext    = LW'(occ_q);
	assign need_evict = (occ_ext >= limit) && (occ_q != '0);

	always_comb begin
		ins_d = !res.hit && (res.pair || proto_q != PROTO_TCP ||
			(flags_q[FLAG_SYN] && !flags_q[FLAG_ACK]));
		if (res.hit && res.hit_rank == '0) begin
			oldest_d = (occ_q == OCC_W'(1)) ? res.hit_slot : res.r1_slot;
		end else begin
			oldest_d = res.r0_slot;
		end
	end

	always_comb begin
		cmd = '0;
		cmd.op = CMD_NONE;
		case (state_q)
			ST_HIT: begin
				cmd.op       = CMD_HIT;
				cmd.slot     = hit_slot_q;
				cmd.rank     = IDX_W'(occ_q - OCC_W'(1));
				cmd.ref_rank = hit_rank_q;
			end
			ST_EVICT: begin
				if (need_evict) begin
					cmd.op = CMD_EVICT;
				end
			end
			ST_FREE: begin
				if (res.vld) begin
					cmd.op   = CMD_INSERT;
					cmd.slot = res.free_slot;
					cmd.rank = IDX_W'(occ_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign ev_ext   = SW'(ev_slot_q);
	assign flow_ext = SW'(flow_slot_q);
	assign cnt_ext  = CW'(occ_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_flows_q <= MAX_FLOWS_RST;
		end else if (cfg_we) begin
			max_flows_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			start_q   <= 1'b0;
			occ_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						start_q <= 1'b1;
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (res.vld) begin
						state_q <= res.hit ? ST_HIT : ST_EVICT;
					end
				end
				ST_HIT: begin
					state_q <= ST_EVICT;
				end
				ST_EVICT: begin
					if (need_evict) begin
						occ_q <= occ_q - OCC_W'(1);
					end else if (ins_q) begin
						start_q <= 1'b1;
						state_q <= ST_FREE;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_FREE: begin
					if (res.vld) begin
						occ_q   <= occ_q + OCC_W'(1);
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				src_q     <= s_tdata[31:0];
				dst_q     <= s_tdata[63:32];
				ports_q   <= {s_tdata[79:64], s_tdata[95:80]};
				proto_q   <= s_tdata[103:96];
				flags_q   <= s_tdata[115:108];
				evicted_q <= 1'b0;
				ev_slot_q <= '0;
			end
			ST_LOOK: begin
				if (res.vld) begin
					hit_slot_q  <= res.hit_slot;
					hit_rank_q  <= res.hit_rank;
					oldest_q    <= oldest_d;
					ins_q       <= ins_d;
					flow_slot_q <= res.hit ? res.hit_slot : '0;
					outc_q      <= res.hit ? OUTC_HIT : (ins_d ? OUTC_NEW : OUTC_DROP);
				end
			end
			ST_EVICT: begin
				if (need_evict && !evicted_q) begin
					evicted_q <= 1'b1;
					ev_slot_q <= oldest_q;
				end
			end
			ST_FREE: begin
				if (res.vld) begin
					flow_slot_q <= res.free_slot;
				end
			end
			ST_DONE: begin
				if (!m_valid_q || m_tready) begin
					m_data_q <= {4'd0, cnt_ext[CFG_W-1:0], flow_ext[OSLOT_W-1:0],
						ev_ext[OSLOT_W-1:0], evicted_q, outc_q};
				end
			end
			default: begin
			end
		endcase
	end

endmodule
